// ----- rtl/kqt_pkg.sv -----
// Shared types and codes for the keyed quantity table.
package kqt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_UPDATE = 2'd2,
    OP_LIST   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STATUS_OK    = 3'd0,
    STATUS_FULL  = 3'd1,
    STATUS_DUP   = 3'd2,
    STATUS_MISS  = 3'd3,
    STATUS_EMPTY = 3'd4
  } status_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] part_key;
    logic signed [31:0] quantity_value;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic        [5:0]  slot_index;
    logic signed [31:0] entry_key;
    logic signed [31:0] entry_quantity;
    logic        [6:0]  entry_count;
    logic               last_result;
  } out_t;

  // Decoded command handed from the front end to the execution engine.
  typedef struct packed {
    opcode_t     op;
    logic        lookup;
    logic [31:0] key;
    logic [31:0] qty;
  } cmd_t;

  typedef enum logic [2:0] {
    ES_IDLE,
    ES_SCAN,
    ES_REPLY,
    ES_LIST_RD,
    ES_LIST_OUT
  } eng_state_t;

endpackage

// ----- rtl/kqt_front.sv -----
// Request front end: decodes each request and holds it in a two-entry command queue.
module kqt_front
  import kqt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  request,
  output logic cmd_valid,
  input  logic cmd_take,
  output cmd_t cmd
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  cmd_t       decoded;

  // Classify the request: every opcode except list needs a key lookup.
  always_comb begin
    decoded.op     = request.opcode;
    decoded.lookup = (request.opcode != OP_LIST);
    decoded.key    = request.part_key;
    decoded.qty    = request.quantity_value;
  end

  assign full      = (count == 2'd2);
  assign accept    = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      entries[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take && cmd_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({accept, cmd_take && cmd_valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/kqt_back.sv -----
// Execution engine: key and quantity memories, linear search sequencer and result register.
module kqt_back
  import kqt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
)
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_take,
  input  cmd_t cmd,
  output logic empty,
  input  logic pop,
  output out_t result
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  logic [31:0] key_mem [TABLE_DEPTH];
  logic [31:0] qty_mem [TABLE_DEPTH];

  eng_state_t       state, state_next;
  cmd_t             cmd_q;
  logic [CNT_W-1:0] fill, fill_next;
  logic [CNT_W-1:0] scan_idx, scan_idx_next;
  logic             pending, pending_next;
  logic             found, found_next;
  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      key_rd;
  logic [31:0]      qty_rd;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             key_we;
  logic             qty_we;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_qty;

  logic             emit;
  logic             go;
  out_t             res;
  logic             out_valid;
  logic             hit;
  logic [32:0]      sum;
  logic [31:0]      sat_qty;

  assign empty = !out_valid;
  assign go    = emit && (!out_valid || pop);
  assign hit   = pending && (key_rd == cmd_q.key);

  // Saturating add of the stored quantity and the signed change.
  always_comb begin
    sum = {qty_rd[31], qty_rd} + {cmd_q.qty[31], cmd_q.qty};
    if (sum[32] != sum[31]) begin
      sat_qty = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat_qty = sum[31:0];
    end
  end

  always_comb begin
    state_next    = state;
    fill_next     = fill;
    scan_idx_next = scan_idx;
    pending_next  = 1'b0;
    found_next    = found;
    cmd_take      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = scan_idx[IDX_W-1:0];
    key_we        = 1'b0;
    qty_we        = 1'b0;
    wr_addr       = fill[IDX_W-1:0];
    wr_qty        = cmd_q.qty;
    emit          = 1'b0;
    res           = '0;
    res.status    = STATUS_OK;
    res.entry_count = 7'(fill);
    res.last_result = 1'b1;

    unique case (state)
      ES_IDLE: begin
        cmd_take = cmd_valid;
        if (cmd_valid) begin
          scan_idx_next = '0;
          found_next    = 1'b0;
          if (!cmd.lookup) begin
            state_next = (fill == '0) ? ES_REPLY : ES_LIST_RD;
          end else if (cmd.op == OP_INSERT && fill == DEPTH_CNT) begin
            state_next = ES_REPLY;
          end else begin
            state_next = ES_SCAN;
          end
        end
      end

      ES_SCAN: begin
        if (hit) begin
          found_next = 1'b1;
          state_next = ES_REPLY;
        end else if (scan_idx < fill) begin
          rd_en         = 1'b1;
          pending_next  = 1'b1;
          scan_idx_next = scan_idx + 1'b1;
        end else begin
          found_next = 1'b0;
          state_next = ES_REPLY;
        end
      end

      ES_REPLY: begin
        emit = 1'b1;
        unique case (cmd_q.op)
          OP_INSERT: begin
            if (fill == DEPTH_CNT) begin
              res.status = STATUS_FULL;
            end else if (found) begin
              res.status         = STATUS_DUP;
              res.slot_index     = 6'(rd_idx);
              res.entry_key      = key_rd;
              res.entry_quantity = qty_rd;
            end else begin
              res.slot_index     = 6'(fill);
              res.entry_key      = cmd_q.key;
              res.entry_quantity = cmd_q.qty;
              res.entry_count    = 7'(fill) + 7'd1;
              key_we             = go;
              qty_we             = go;
              if (go) begin
                fill_next = fill + 1'b1;
              end
            end
          end
          OP_SEARCH, OP_UPDATE: begin
            if (found) begin
              res.slot_index = 6'(rd_idx);
              res.entry_key  = key_rd;
              if (cmd_q.op == OP_UPDATE) begin
                res.entry_quantity = sat_qty;
                qty_we             = go;
                wr_addr            = rd_idx;
                wr_qty             = sat_qty;
              end else begin
                res.entry_quantity = qty_rd;
              end
            end else begin
              res.status = STATUS_MISS;
            end
          end
          OP_LIST: begin
            res.status      = STATUS_EMPTY;
            res.entry_count = '0;
          end
          default: begin
            res.status = STATUS_MISS;
          end
        endcase
        if (go) begin
          state_next = ES_IDLE;
        end
      end

      ES_LIST_RD: begin
        rd_en      = 1'b1;
        state_next = ES_LIST_OUT;
      end

      ES_LIST_OUT: begin
        emit               = 1'b1;
        res.slot_index     = 6'(rd_idx);
        res.entry_key      = key_rd;
        res.entry_quantity = qty_rd;
        res.last_result    = (scan_idx + 1'b1 == fill);
        if (go) begin
          if (res.last_result) begin
            state_next = ES_IDLE;
          end else begin
            scan_idx_next = scan_idx + 1'b1;
            state_next    = ES_LIST_RD;
          end
        end
      end

      default: begin
        state_next = ES_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ES_IDLE;
      fill      <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      pending <= pending_next;
      if (go) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    found    <= found_next;
    if (cmd_take) begin
      cmd_q <= cmd;
    end
    if (go) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= cmd_q.key;
    end
    if (qty_we) begin
      qty_mem[wr_addr] <= wr_qty;
    end
    if (rd_en) begin
      key_rd <= key_mem[rd_addr];
      qty_rd <= qty_mem[rd_addr];
      rd_idx <= rd_addr;
    end
  end

endmodule

// ----- rtl/keyed_quantity_table.sv -----
// Top level of the keyed quantity table: front end, command queue and execution engine.
//
// The keyed quantity table holds up to TABLE_DEPTH entries of a 32-bit key and a
// 32-bit signed quantity, filled in slot order and searched linearly by key. A
// request is taken when push is high and full is low; it is decoded and parked
// in a two-entry command queue, so the host can hand over the next request while
// the engine is still busy. The engine reads one stored entry per cycle from its
// memories: insert, search and update walk the table through that single read
// port until a match or the end, and an insert into a full table skips the walk.
// Update adds the change and saturates at the signed 32-bit limits. List returns
// one result per entry in slot order, with last_result marking the final one; on
// an empty table it returns a single table-empty result. Results wait in an output
// register and are taken when pop is high and empty is low; the engine stalls
// while that register is held, and nothing is dropped.
module keyed_quantity_table
  import kqt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
)
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  request,
  output logic empty,
  input  logic pop,
  output out_t result
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  // The front end decodes requests and buffers them ahead of the engine.
  kqt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  // The engine owns the table storage, the fill count and the result register.
  kqt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // A shown result never claims more entries than the table can hold.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.entry_count <= 7'(TABLE_DEPTH))
    else $error("entry_count exceeds table depth");

  // A successful result always names a slot that is in use. The slot is widened to the
  // count's width so that a full table of 64 entries compares correctly.
  a_slot_in_use: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == STATUS_OK) |-> {1'b0, result.slot_index} < result.entry_count)
    else $error("ok result names a slot beyond the fill count");

  // Table-full is only reported when the table really is full.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == STATUS_FULL) |-> result.entry_count == 7'(TABLE_DEPTH))
    else $error("table full reported below depth");

  // Table-empty is a single final result with no entries.
  a_empty_list: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == STATUS_EMPTY)
      |-> (result.entry_count == 7'd0 && result.last_result))
    else $error("table empty result is malformed");

  // The engine only takes a command that the queue holds.
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid)
    else $error("engine took a command from an empty queue");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the keyed quantity table: directed corners, random traffic, stalls.
module tb_top;
  import kqt_pkg::*;

  // The table size matches the block's default and is passed to the instance explicitly.
  localparam int TABLE_DEPTH = 64;
  localparam int N_RANDOM = 460;
  // The longest idle gap that either side ever inserts.
  localparam int MAX_GAP = 40;
  // The long receiver hold-off that lets the command queue and the output register fill up.
  localparam int HOLD_CYCLES = 400;
  // A list walks the whole table, and the quiet stretch after the last awaited result
  // is long enough for that, so any stray extra result is caught.
  localparam int DRAIN_CYCLES = 300;
  // The slowest correct run: every request is a full list whose 64 results each wait
  // out the longest receiver gap, plus the sender's longest gap and the engine's own
  // walk. That figure is doubled, and the deliberate hold-offs are added on top.
  localparam int CYCLE_LIMIT =
    2 * (N_RANDOM + 25) * (MAX_GAP + 150 + TABLE_DEPTH * (MAX_GAP + 4)) + 4 * HOLD_CYCLES;

  // The scoreboard keeps its own copy of the table. Each accepted request is run against
  // that copy at once, and the replies it should cause are queued in order. Every result
  // the block hands out is then compared with the oldest awaited reply.
  class table_scoreboard;
    logic [31:0] keys [TABLE_DEPTH];
    logic [31:0] qtys [TABLE_DEPTH];
    int          fill;
    out_t        awaited_results [$];
    int          failures;
    int          results_checked;
    int          op_count [4];
    int          status_count [5];
    int          saturations;

    function new();
      fill = 0;
      failures = 0;
      results_checked = 0;
      saturations = 0;
      foreach (op_count[i]) op_count[i] = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    // Linear search over the filled slots only; -1 when the key is not held.
    function int find_slot(logic [31:0] key);
      for (int i = 0; i < fill; i++) begin
        if (keys[i] == key) return i;
      end
      return -1;
    endfunction

    function int pending_count();
      return awaited_results.size();
    endfunction

    function void await_reply(status_t status, int slot, int last);
      out_t reply;
      reply = '0;
      reply.status = status;
      reply.entry_count = 7'(fill);
      reply.last_result = 1'b1;
      if (slot >= 0) begin
        reply.slot_index = 6'(slot);
        reply.entry_key = keys[slot];
        reply.entry_quantity = qtys[slot];
        reply.last_result = 1'(last);
      end
      status_count[status]++;
      awaited_results.push_back(reply);
    endfunction

    function void note_request(in_t req);
      int     slot;
      longint sum;
      op_count[req.opcode]++;
      case (req.opcode)
        OP_INSERT: begin
          // A full table refuses the request before the duplicate check is made.
          if (fill >= TABLE_DEPTH) begin
            await_reply(STATUS_FULL, -1, 1);
          end else begin
            slot = find_slot(req.part_key);
            if (slot >= 0) begin
              await_reply(STATUS_DUP, slot, 1);
            end else begin
              keys[fill] = req.part_key;
              qtys[fill] = req.quantity_value;
              fill++;
              await_reply(STATUS_OK, fill - 1, 1);
            end
          end
        end
        OP_SEARCH: begin
          slot = find_slot(req.part_key);
          await_reply(slot < 0 ? STATUS_MISS : STATUS_OK, slot, 1);
        end
        OP_UPDATE: begin
          slot = find_slot(req.part_key);
          if (slot < 0) begin
            await_reply(STATUS_MISS, -1, 1);
          end else begin
            // The sum is formed wide and then clamped to the signed 32-bit range.
            sum = longint'($signed(qtys[slot])) + longint'($signed(req.quantity_value));
            if (sum > 64'sd2147483647) begin
              sum = 64'sd2147483647;
              saturations++;
            end else if (sum < -64'sd2147483648) begin
              sum = -64'sd2147483648;
              saturations++;
            end
            qtys[slot] = sum[31:0];
            await_reply(STATUS_OK, slot, 1);
          end
        end
        OP_LIST: begin
          if (fill == 0) begin
            await_reply(STATUS_EMPTY, -1, 1);
          end else begin
            for (int i = 0; i < fill; i++) begin
              await_reply(STATUS_OK, i, (i == fill - 1) ? 1 : 0);
            end
          end
        end
      endcase
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (awaited_results.size() == 0) begin
        $error("result with nothing awaited: status %0d slot %0d key %0h",
               got.status, got.slot_index, got.entry_key);
        failures++;
        return;
      end
      want = awaited_results.pop_front();
      results_checked++;
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
      check_field("entry_key", want.entry_key, got.entry_key);
      check_field("entry_quantity", want.entry_quantity, got.entry_quantity);
      check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      check_field("last_result", 32'(want.last_result), 32'(got.last_result));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  in_t  request;
  logic empty;
  logic pop;
  out_t result;

  table_scoreboard board = new();

  // Set by the stimulus to ask the receiver for one long hold-off; the receiver clears it.
  bit hold_request = 1'b0;
  int hold_count = 0;
  // While set, neither side inserts idle cycles, so back-to-back traffic is seen too.
  bit steady_run = 1'b0;
  int cycle_count = 0;

  keyed_quantity_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .request(request),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung block ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Results are sampled at the rising edge, where pop and empty both hold the settled
  // values they had before that edge.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      board.check_result(result);
    end
  end

  // Idle gaps: none during a steady run; otherwise mostly none or short, now and then a long one.
  function automatic int idle_gap();
    int roll;
    if (steady_run) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(MAX_GAP, 8);
  endfunction

  function automatic logic [31:0] corner_word();
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // Keys come from the table itself part of the time so that searches and updates hit;
  // the rest are corner words, a small range that collides often, or full random words.
  function automatic logic [31:0] pick_key(int held_pct);
    int roll;
    roll = $urandom_range(99);
    if (board.fill > 0 && roll < held_pct) return board.keys[$urandom_range(board.fill - 1)];
    roll = $urandom_range(99);
    if (roll < 15) return corner_word();
    if (roll < 50) return 32'($urandom_range(300));
    return $urandom;
  endfunction

  // Quantities mix corner words, full random words that make updates saturate, and
  // small signed changes.
  function automatic logic [31:0] pick_quantity();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return corner_word();
    if (roll < 55) return $urandom;
    return 32'($urandom_range(2000)) - 32'd1000;
  endfunction

  // Offers one request after an optional idle gap and returns once the block has taken it.
  // Push is only ever assigned once per falling edge, so a request that follows directly
  // keeps push high without a glitch.
  task automatic send_request(opcode_t op, logic [31:0] key, logic [31:0] qty);
    in_t req;
    int  gap;
    req.opcode = op;
    req.part_key = key;
    req.quantity_value = qty;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    request <= req;
    do @(posedge clk); while (full);
    board.note_request(req);
  endtask

  // The receiver pops with random gaps, and on request stops popping for a long stretch
  // that it counts itself while the sender keeps offering requests.
  initial begin : result_drain
    int stall;
    stall = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_count++;
        hold_request = 1'b0;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        stall = idle_gap();
      end
    end
  end

  initial begin : stimulus
    int roll;
    rst = 1'b1;
    push = 1'b0;
    request = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, starting from the empty table: an empty list, misses on search and
    // update, inserts at the extreme keys and quantities, a duplicate insert, updates
    // that saturate at both limits and one that lands exactly on a limit, searches and lists.
    send_request(OP_LIST, 32'h0, 32'h0);
    send_request(OP_SEARCH, 32'd5, 32'h0);
    send_request(OP_UPDATE, 32'd5, 32'd7);
    send_request(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h8000_0000, 32'd5);
    send_request(OP_SEARCH, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_UPDATE, 32'h8000_0000, 32'd1);
    send_request(OP_UPDATE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_UPDATE, 32'h0000_0000, 32'h7FFF_FFFF);
    send_request(OP_UPDATE, 32'h0000_0000, 32'h8000_0000);
    send_request(OP_UPDATE, 32'hFFFF_FFFF, 32'h8000_0000);
    send_request(OP_SEARCH, 32'h0000_0000, 32'h0);
    send_request(OP_SEARCH, 32'd12345, 32'h0);
    send_request(OP_LIST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(OP_LIST, 32'h0, 32'h0);

    // Random part. Inserts favor fresh keys so the table fills about halfway through,
    // after which inserts are refused as full; searches and updates mostly hit held keys.
    for (int i = 0; i < N_RANDOM; i++) begin
      steady_run = ((i / 50) % 4 == 2);
      if (i == 0 || i == 300) hold_request = 1'b1;
      roll = $urandom_range(99);
      if (roll < 30) begin
        send_request(OP_INSERT, pick_key(25), pick_quantity());
      end else if (roll < 58) begin
        send_request(OP_SEARCH, pick_key(60), pick_quantity());
      end else if (roll < 92) begin
        send_request(OP_UPDATE, pick_key(70), pick_quantity());
      end else begin
        send_request(OP_LIST, pick_key(0), pick_quantity());
      end
    end
    steady_run = 1'b0;
    @(negedge clk);
    push <= 1'b0;

    while (board.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d inserts, %0d searches, %0d updates, %0d lists; %0d results checked;",
             board.op_count[OP_INSERT], board.op_count[OP_SEARCH],
             board.op_count[OP_UPDATE], board.op_count[OP_LIST], board.results_checked);
    $display({"table held %0d of %0d; %0d full, %0d duplicate, %0d missing, %0d empty, ",
              "%0d clamped, %0d hold-offs"},
             board.fill, TABLE_DEPTH, board.status_count[STATUS_FULL],
             board.status_count[STATUS_DUP], board.status_count[STATUS_MISS],
             board.status_count[STATUS_EMPTY], board.saturations, hold_count);
    if (board.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
